### rtl/cbz_pkg.sv
// Shared types and constants for the cubic Bezier evaluate/split pipeline.
package cbz_pkg;

    localparam int COORD_BITS  = 24;
    localparam int T_FRAC_BITS = 16;
    localparam int T_BITS      = T_FRAC_BITS + 1;
    localparam int TAN_BITS    = COORD_BITS + 3;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + T_BITS + 1;
    localparam int NUM_STAGES  = 7;

    localparam logic [T_BITS-1:0]           T_ONE      = T_BITS'(1) << T_FRAC_BITS;
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (T_FRAC_BITS - 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } pt_t;

    // load enables for the two register stages of one lerp
    typedef struct packed {
        logic mul;
        logic add;
    } lerp_en_t;

endpackage

### rtl/cubic_bezier_eval_split_core.sv
// Top level: pipelined de Casteljau evaluation and split of a cubic Bezier.
//
// Usage:
//   Input channel: in_valid/in_stall with four control points (signed Q15.8)
//   and param_t (unsigned Q1.16, values above 1.0 clamp to 1.0).
//   Output channel: out_valid/out_stall with the split controls P10 and P20,
//   the curve point P30 and the tangent 3*(P21-P20).
//   Seven register stages: input register, then a product stage and a
//   round-and-add stage for each of the three lerp levels.
//   Throughput is one item per cycle while out_stall is low; each stage
//   holds one item and the per-stage ready chain lets an item move into any
//   empty slot, so bubbles fill while the receiver stalls. in_stall rises only
//   when every stage from the input up to the stalled output register is
//   occupied.
//   Reset clears the stage valid bits; the datapath registers are not reset.
//   No configuration and no state carries between items.
module cubic_bezier_eval_split_core
    import cbz_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] p0_x,
    input  logic signed [COORD_BITS-1:0] p0_y,
    input  logic signed [COORD_BITS-1:0] p1_x,
    input  logic signed [COORD_BITS-1:0] p1_y,
    input  logic signed [COORD_BITS-1:0] p2_x,
    input  logic signed [COORD_BITS-1:0] p2_y,
    input  logic signed [COORD_BITS-1:0] p3_x,
    input  logic signed [COORD_BITS-1:0] p3_y,
    input  logic [T_BITS-1:0]            param_t,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] sub_c1_x,
    output logic signed [COORD_BITS-1:0] sub_c1_y,
    output logic signed [COORD_BITS-1:0] sub_c2_x,
    output logic signed [COORD_BITS-1:0] sub_c2_y,
    output logic signed [COORD_BITS-1:0] curve_x,
    output logic signed [COORD_BITS-1:0] curve_y,
    output logic signed [TAN_BITS-1:0]   tangent_x,
    output logic signed [TAN_BITS-1:0]   tangent_y
);

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] ready;

    // stage 0 registers
    pt_t               p0_reg, p1_reg, p2_reg, p3_reg;
    logic [T_BITS-1:0] t_sat;
    logic [T_BITS-1:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;

    // lerp outputs
    pt_t p10, p11, p12, p20, p21, p30;

    // carried results
    pt_t p10_s3_reg, p10_s4_reg, p10_s5_reg, p10_s6_reg;
    pt_t p20_s5_reg, p20_s6_reg;

    logic signed [DIFF_BITS-1:0] tdx, tdy;
    logic signed [TAN_BITS-1:0]  tan_x_next, tan_y_next;
    logic signed [TAN_BITS-1:0]  tan_x_s5_reg, tan_y_s5_reg;
    logic signed [TAN_BITS-1:0]  tan_x_s6_reg, tan_y_s6_reg;

    lerp_en_t en_l1, en_l2, en_l3;

    // ready chain: a stage loads when it is empty or its successor loads
    always_comb
    begin
        ready[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !v_reg[k] || ready[k+1];
        end
        v_next = v_reg;
        v_next[0] = ready[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (ready[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall = !ready[0];
    assign t_sat    = (param_t > T_ONE) ? T_ONE : param_t;

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            p0_reg <= '{x: p0_x, y: p0_y};
            p1_reg <= '{x: p1_x, y: p1_y};
            p2_reg <= '{x: p2_x, y: p2_y};
            p3_reg <= '{x: p3_x, y: p3_y};
            t0_reg <= t_sat;
        end
        if (ready[1])
        begin
            t1_reg <= t0_reg;
        end
        if (ready[2])
        begin
            t2_reg <= t1_reg;
        end
        if (ready[3])
        begin
            t3_reg     <= t2_reg;
            p10_s3_reg <= p10;
        end
        if (ready[4])
        begin
            t4_reg     <= t3_reg;
            p10_s4_reg <= p10_s3_reg;
        end
        if (ready[5])
        begin
            p10_s5_reg   <= p10_s4_reg;
            p20_s5_reg   <= p20;
            tan_x_s5_reg <= tan_x_next;
            tan_y_s5_reg <= tan_y_next;
        end
        if (ready[6])
        begin
            p10_s6_reg   <= p10_s5_reg;
            p20_s6_reg   <= p20_s5_reg;
            tan_x_s6_reg <= tan_x_s5_reg;
            tan_y_s6_reg <= tan_y_s5_reg;
        end
    end

    assign en_l1 = '{mul: ready[1], add: ready[2]};
    assign en_l2 = '{mul: ready[3], add: ready[4]};
    assign en_l3 = '{mul: ready[5], add: ready[6]};

    cbz_lerp u_l10 (.clk(clk), .en(en_l1), .a(p0_reg), .b(p1_reg), .t(t0_reg), .q(p10));
    cbz_lerp u_l11 (.clk(clk), .en(en_l1), .a(p1_reg), .b(p2_reg), .t(t0_reg), .q(p11));
    cbz_lerp u_l12 (.clk(clk), .en(en_l1), .a(p2_reg), .b(p3_reg), .t(t0_reg), .q(p12));
    cbz_lerp u_l20 (.clk(clk), .en(en_l2), .a(p10),    .b(p11),    .t(t2_reg), .q(p20));
    cbz_lerp u_l21 (.clk(clk), .en(en_l2), .a(p11),    .b(p12),    .t(t2_reg), .q(p21));
    cbz_lerp u_l30 (.clk(clk), .en(en_l3), .a(p20),    .b(p21),    .t(t4_reg), .q(p30));

    // tangent 3*(P21-P20) as d + 2d, formed beside the last product stage
    always_comb
    begin
        tdx        = DIFF_BITS'(p21.x) - DIFF_BITS'(p20.x);
        tdy        = DIFF_BITS'(p21.y) - DIFF_BITS'(p20.y);
        tan_x_next = TAN_BITS'(tdx) + (TAN_BITS'(tdx) <<< 1);
        tan_y_next = TAN_BITS'(tdy) + (TAN_BITS'(tdy) <<< 1);
    end

    assign out_valid = v_reg[NUM_STAGES-1];
    assign sub_c1_x  = p10_s6_reg.x;
    assign sub_c1_y  = p10_s6_reg.y;
    assign sub_c2_x  = p20_s6_reg.x;
    assign sub_c2_y  = p20_s6_reg.y;
    assign curve_x   = p30.x;
    assign curve_y   = p30.y;
    assign tangent_x = tan_x_s6_reg;
    assign tangent_y = tan_y_s6_reg;

    // input is held back only when the first stage is occupied
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v_reg[0])
        else $error("in_stall raised with stage 0 empty");

    // an input transfer lands in stage 0
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v_reg[0])
        else $error("accepted item lost at stage 0");

    // an item moving into the output stage shows up there
    a_last_move: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NUM_STAGES-2] && ready[NUM_STAGES-1]) |=> out_valid)
        else $error("item lost entering the output stage");

    // clamped parameter never exceeds one
    a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> (t0_reg <= T_ONE))
        else $error("parameter above one in pipeline");

endmodule

### rtl/cbz_lerp.sv
// Two-stage point lerp a + t*(b-a), product stage then round-and-add stage.
module cbz_lerp
    import cbz_pkg::*;
(
    input  logic              clk,
    input  lerp_en_t          en,
    input  pt_t               a,
    input  pt_t               b,
    input  logic [T_BITS-1:0] t,
    output pt_t               q
);

    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic signed [T_BITS:0]      ts;
    logic signed [PROD_BITS-1:0] prod_x_next;
    logic signed [PROD_BITS-1:0] prod_y_next;
    logic signed [PROD_BITS-1:0] prod_x_reg;
    logic signed [PROD_BITS-1:0] prod_y_reg;
    logic signed [PROD_BITS-1:0] rnd_x;
    logic signed [PROD_BITS-1:0] rnd_y;
    pt_t                         a_reg;
    pt_t                         q_next;
    pt_t                         q_reg;

    always_comb
    begin
        dx          = DIFF_BITS'(b.x) - DIFF_BITS'(a.x);
        dy          = DIFF_BITS'(b.y) - DIFF_BITS'(a.y);
        ts          = $signed({1'b0, t});
        prod_x_next = dx * ts;
        prod_y_next = dy * ts;
    end

    // add half then floor; the low coordinate bits of the scaled value suffice
    always_comb
    begin
        rnd_x    = prod_x_reg + ROUND_HALF;
        rnd_y    = prod_y_reg + ROUND_HALF;
        q_next.x = a_reg.x + $signed(rnd_x[T_FRAC_BITS +: COORD_BITS]);
        q_next.y = a_reg.y + $signed(rnd_y[T_FRAC_BITS +: COORD_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            a_reg      <= a;
        end
        if (en.add)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
